### hw/rtl/wst_pkg.sv
// Shared types and constants for the workout session tracker.
package wst_pkg;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_COUNTDOWN = 3'd1,
		PH_ACTIVE    = 3'd2,
		PH_PAUSED    = 3'd3,
		PH_FINISHED  = 3'd4,
		PH_ABORTED   = 3'd5,
		PH_RECOVERY  = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_ARG    = 3'd1,
		ST_BAD_STATE  = 3'd2,
		ST_BAD_SAMPLE = 3'd3,
		ST_REGRESSION = 3'd4,
		ST_OVERFLOW   = 3'd5,
		ST_BAD_CONFIG = 3'd6
	} status_t;

	localparam logic [2:0] CMD_START   = 3'd0;
	localparam logic [2:0] CMD_PAUSE   = 3'd1;
	localparam logic [2:0] CMD_RESUME  = 3'd2;
	localparam logic [2:0] CMD_FINISH  = 3'd3;
	localparam logic [2:0] CMD_ABORT   = 3'd4;
	localparam logic [2:0] CMD_RECOVER = 3'd5;

	localparam logic [2:0] REG_COUNTDOWN = 3'd0;
	localparam logic [2:0] REG_STRIDE    = 3'd1;
	localparam logic [2:0] REG_ENERGY    = 3'd2;
	localparam logic [2:0] REG_STEP_LIM  = 3'd3;
	localparam logic [2:0] REG_FLOOR     = 3'd4;
	localparam logic [2:0] REG_CEILING   = 3'd5;

	localparam logic [63:0] PACE_SCALE = 64'd1000000;

	typedef struct packed {
		logic        req_type;
		logic [2:0]  command_code;
		logic [63:0] time_ms;
		logic [15:0] step_increment;
		logic        pulse_present;
		logic [7:0]  pulse_bpm;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  session_state;
		logic [63:0] total_steps;
		logic [63:0] total_distance_mm;
		logic [63:0] total_energy;
		logic [63:0] active_time_ms;
		logic        pulse_stats_valid;
		logic [7:0]  pulse_min_bpm;
		logic [7:0]  pulse_max_bpm;
		logic [7:0]  pulse_average_bpm;
		logic [63:0] pace_ms_per_km;
	} rsp_t;

	typedef enum logic [1:0] {
		DV_IDLE = 2'd0,
		DV_RUN  = 2'd1,
		DV_DONE = 2'd2
	} div_state_t;

	typedef enum logic [3:0] {
		SQ_IDLE   = 4'd0,
		SQ_ADV    = 4'd1,
		SQ_MUL_W  = 4'd2,
		SQ_MUL_D  = 4'd3,
		SQ_MUL_E  = 4'd4,
		SQ_APPLY  = 4'd5,
		SQ_MUL_P  = 4'd6,
		SQ_DIV_A  = 4'd7,
		SQ_WAIT_A = 4'd8,
		SQ_DIV_P  = 4'd9,
		SQ_WAIT_P = 4'd10,
		SQ_OUT    = 4'd11
	} seq_t;

endpackage

### hw/rtl/wst_if.sv
// Valid/ready channel interface.
interface wst_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/wst_div.sv
// Radix-2 restoring divider, 64 by 64 bits, one quotient bit per cycle.
module wst_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);
	import wst_pkg::*;

	div_state_t  state_q, state_d;
	logic [63:0] rem_q, quo_q, dvs_q;
	logic [5:0]  cnt_q;
	logic [64:0] trial;
	logic [64:0] shifted;

	assign shifted = {rem_q, quo_q[63]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			DV_IDLE: if (start) state_d = DV_RUN;
			DV_RUN:  if (cnt_q == 6'd63) state_d = DV_DONE;
			DV_DONE: state_d = DV_IDLE;
			default: state_d = DV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == DV_IDLE) cnt_q <= '0;
			else if (state_q == DV_RUN) cnt_q <= cnt_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == DV_IDLE && start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (state_q == DV_RUN) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted[63:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign done     = (state_q == DV_DONE);
	assign quotient = quo_q;
endmodule

### hw/rtl/workout_session_tracker.sv
// Top level of the workout session tracker.
// channel | dir | payload
// req     | in  | req_type, command_code, time_ms, step_increment, pulse_present, pulse_bpm
// rsp     | out | status, session_state, totals, pulse stats, pace
// cfg     | in  | cfg_we, cfg_index, cfg_wdata (write only)
// A request that is taken runs through the update steps (two 64x32 products, each as two
// 32x32 halves), two divider passes (start, 64 quotient bits, done) and an output step
// before the response is valid; a new request is taken only once the last one is through.
// Reset clears the sequencer, session state and totals and loads the register defaults.
// req ready is low while a request is in work; a stalled response holds, and the
// next request is taken in the cycle the response is taken.
module workout_session_tracker (
	input  logic                clk,
	input  logic                arst_n,
	wst_if.sink                 req,
	wst_if.source               rsp,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_wdata
);
	import wst_pkg::*;

	logic [31:0] cd_len_q;
	logic [15:0] stride_q, energy_q, steplim_q;
	logic [7:0]  floor_q, ceil_q;

	phase_t      phase_q;
	logic [63:0] last_q, act_q, steps_q, dist_q, en_q, wsum_q, wtime_q;
	logic [31:0] spent_q;
	logic [7:0]  pnow_q, plow_q, phigh_q;
	logic        pnv_q, pseen_q;

	// working copy
	phase_t      n_phase_q;
	logic [63:0] n_act_q, n_wsum_q, n_wtime_q, a_q;
	logic [31:0] n_spent_q;
	logic [63:0] w_q, dinc_q, einc_q, pscaled_q;
	logic        pace_ok_q;

	seq_t        seq_q, seq_d;
	req_t        r_q;
	logic [2:0]  stat_q;
	logic        half_q;
	logic [63:0] avg_q;
	rsp_t        out_q;
	logic        rvalid_q;

	// shared 32x32 multiplier
	logic [31:0] ma, mb;
	logic [63:0] mp;
	logic [63:0] mlo_q;
	assign mp = ma * mb;

	logic        dstart, ddone;
	logic [63:0] ddividend, ddivisor, dquot;

	wst_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .dividend(ddividend),
		.divisor(ddivisor), .done(ddone), .quotient(dquot)
	);

	logic cfg_good;
	assign cfg_good = cd_len_q != '0 && stride_q != '0 && energy_q != '0 && steplim_q != '0 &&
		floor_q != '0 && floor_q <= ceil_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cd_len_q  <= 32'd3000;
			stride_q  <= 16'd700;
			energy_q  <= 16'd40;
			steplim_q <= 16'd100;
			floor_q   <= 8'd30;
			ceil_q    <= 8'd220;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COUNTDOWN: cd_len_q  <= cfg_wdata;
				REG_STRIDE:    stride_q  <= cfg_wdata[15:0];
				REG_ENERGY:    energy_q  <= cfg_wdata[15:0];
				REG_STEP_LIM:  steplim_q <= cfg_wdata[15:0];
				REG_FLOOR:     floor_q   <= cfg_wdata[7:0];
				REG_CEILING:   ceil_q    <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// advance: elapsed and active contribution
	logic [63:0] elapsed, remaining, act_c;
	logic        regress;
	logic [64:0] act_sum;
	assign regress = r_q.time_ms < last_q;
	assign elapsed = r_q.time_ms - last_q;
	assign remaining = (spent_q >= cd_len_q) ? 64'd0 : {32'd0, cd_len_q - spent_q};
	assign act_sum = {1'b0, act_q} + {1'b0, a_q};

	always_comb begin
		act_c = '0;
		if (phase_q == PH_COUNTDOWN && elapsed >= remaining) act_c = elapsed - remaining;
		else if (phase_q == PH_ACTIVE) act_c = elapsed;
	end

	// multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (seq_q)
			SQ_MUL_W: begin
				ma = {24'd0, pnow_q};
				mb = half_q ? a_q[63:32] : a_q[31:0];
			end
			SQ_MUL_D: begin
				ma = {16'd0, r_q.step_increment};
				mb = {16'd0, stride_q};
			end
			SQ_MUL_E: begin
				ma = {16'd0, r_q.step_increment};
				mb = {16'd0, energy_q};
			end
			SQ_MUL_P: begin
				ma = PACE_SCALE[31:0];
				mb = half_q ? act_q[63:32] : act_q[31:0];
			end
			default: ;
		endcase
	end

	logic [95:0] wide;
	assign wide = {mp, 32'd0} + {32'd0, mlo_q};

	// apply step checks
	logic [64:0] s_sum, d_sum, e_sum, ws_sum, wt_sum;
	assign s_sum  = {1'b0, steps_q} + {49'd0, r_q.step_increment};
	assign d_sum  = {1'b0, dist_q} + {1'b0, dinc_q};
	assign e_sum  = {1'b0, en_q} + {1'b0, einc_q};
	assign ws_sum = {1'b0, wsum_q} + {1'b0, w_q};
	assign wt_sum = {1'b0, wtime_q} + {1'b0, a_q};

	logic       is_cmd_ok;
	logic [2:0] cmd_stat;
	phase_t     cmd_phase;
	logic       cmd_clr;
	always_comb begin
		cmd_stat  = ST_OK;
		cmd_phase = n_phase_q;
		cmd_clr   = 1'b0;
		case (r_q.command_code)
			CMD_START:
				if (n_phase_q != PH_IDLE) cmd_stat = ST_BAD_STATE;
				else cmd_phase = PH_COUNTDOWN;
			CMD_PAUSE:
				if (n_phase_q != PH_ACTIVE) cmd_stat = ST_BAD_STATE;
				else cmd_phase = PH_PAUSED;
			CMD_RESUME:
				if (n_phase_q != PH_PAUSED) cmd_stat = ST_BAD_STATE;
				else cmd_phase = PH_ACTIVE;
			CMD_FINISH:
				if (n_phase_q != PH_ACTIVE && n_phase_q != PH_PAUSED) cmd_stat = ST_BAD_STATE;
				else begin
					cmd_phase = PH_FINISHED;
					cmd_clr   = 1'b1;
				end
			CMD_ABORT:
				if (n_phase_q != PH_COUNTDOWN && n_phase_q != PH_ACTIVE &&
					n_phase_q != PH_PAUSED && n_phase_q != PH_RECOVERY)
					cmd_stat = ST_BAD_STATE;
				else begin
					cmd_phase = PH_ABORTED;
					cmd_clr   = 1'b1;
				end
			default:
				if (n_phase_q != PH_RECOVERY) cmd_stat = ST_BAD_STATE;
				else begin
					cmd_phase = PH_PAUSED;
					cmd_clr   = 1'b1;
				end
		endcase
	end
	assign is_cmd_ok = cmd_stat == ST_OK;

	logic samp_ovf;
	assign samp_ovf = s_sum[64] || d_sum[64] || e_sum[64];

	assign req.ready = (seq_q == SQ_IDLE) && (!rvalid_q || rsp.ready);

	always_comb begin
		seq_d = seq_q;
		unique case (seq_q)
			SQ_IDLE:   if (req.valid && req.ready) seq_d = SQ_ADV;
			SQ_ADV:    seq_d = SQ_MUL_W;
			SQ_MUL_W:  if (half_q) seq_d = SQ_MUL_D;
			SQ_MUL_D:  seq_d = SQ_MUL_E;
			SQ_MUL_E:  seq_d = SQ_APPLY;
			SQ_APPLY:  seq_d = SQ_MUL_P;
			SQ_MUL_P:  if (half_q) seq_d = SQ_DIV_A;
			SQ_DIV_A:  seq_d = SQ_WAIT_A;
			SQ_WAIT_A: if (ddone) seq_d = SQ_DIV_P;
			SQ_DIV_P:  seq_d = SQ_WAIT_P;
			SQ_WAIT_P: if (ddone) seq_d = SQ_OUT;
			SQ_OUT:    seq_d = SQ_IDLE;
			default:   seq_d = SQ_IDLE;
		endcase
	end

	assign dstart    = (seq_q == SQ_DIV_A) || (seq_q == SQ_DIV_P);
	assign ddividend = (seq_q == SQ_DIV_A) ? wsum_q : pscaled_q;
	assign ddivisor  = (seq_q == SQ_DIV_A) ? wtime_q : dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q    <= SQ_IDLE;
			half_q   <= 1'b0;
			rvalid_q <= 1'b0;
			phase_q  <= PH_IDLE;
			last_q   <= '0;
			spent_q  <= '0;
			act_q    <= '0;
			steps_q  <= '0;
			dist_q   <= '0;
			en_q     <= '0;
			pnow_q   <= '0;
			pnv_q    <= 1'b0;
			pseen_q  <= 1'b0;
			plow_q   <= '0;
			phigh_q  <= '0;
			wsum_q   <= '0;
			wtime_q  <= '0;
		end else begin
			seq_q <= seq_d;
			if (seq_q == SQ_OUT) rvalid_q <= 1'b1;
			else if (rvalid_q && rsp.ready) rvalid_q <= 1'b0;
			if (seq_q == SQ_MUL_W || seq_q == SQ_MUL_P) half_q <= !half_q;
			if (seq_q == SQ_APPLY && stat_q == ST_OK) begin
				if (!r_q.req_type) begin
					if (is_cmd_ok) begin
						phase_q <= cmd_phase;
						spent_q <= (r_q.command_code == CMD_START) ? 32'd0 : n_spent_q;
						pnv_q   <= pnv_q && !cmd_clr;
					end
				end else if (!(n_phase_q == PH_ACTIVE && samp_ovf)) begin
					phase_q <= n_phase_q;
					spent_q <= n_spent_q;
					if (n_phase_q == PH_ACTIVE) begin
						steps_q <= s_sum[63:0];
						dist_q  <= d_sum[63:0];
						en_q    <= e_sum[63:0];
						pnv_q   <= r_q.pulse_present;
						if (r_q.pulse_present) begin
							pnow_q  <= r_q.pulse_bpm;
							pseen_q <= 1'b1;
							if (!pseen_q || r_q.pulse_bpm < plow_q) plow_q <= r_q.pulse_bpm;
							if (!pseen_q || r_q.pulse_bpm > phigh_q) phigh_q <= r_q.pulse_bpm;
						end
					end
				end
				if ((!r_q.req_type && is_cmd_ok) ||
					(r_q.req_type && !(n_phase_q == PH_ACTIVE && samp_ovf))) begin
					last_q  <= r_q.time_ms;
					act_q   <= n_act_q;
					wsum_q  <= n_wsum_q;
					wtime_q <= n_wtime_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (seq_q)
			SQ_IDLE: if (req.valid && req.ready) r_q <= req.payload;
			SQ_ADV: begin
				a_q       <= act_c;
				n_act_q   <= act_c + act_q;
				if (phase_q == PH_COUNTDOWN && elapsed >= remaining) begin
					n_phase_q <= PH_ACTIVE;
					n_spent_q <= cd_len_q;
				end else if (phase_q == PH_COUNTDOWN) begin
					n_phase_q <= phase_q;
					n_spent_q <= spent_q + elapsed[31:0];
				end else begin
					n_phase_q <= phase_q;
					n_spent_q <= spent_q;
				end
				if (!cfg_good) stat_q <= ST_BAD_CONFIG;
				else if (!r_q.req_type) begin
					if (r_q.command_code > CMD_RECOVER) stat_q <= ST_BAD_ARG;
					else if (regress) stat_q <= ST_REGRESSION;
					else stat_q <= ST_OK;
				end else begin
					if (phase_q != PH_COUNTDOWN && phase_q != PH_ACTIVE && phase_q != PH_PAUSED)
						stat_q <= ST_BAD_STATE;
					else if ({48'd0, r_q.step_increment} > {48'd0, steplim_q} ||
						(r_q.pulse_present && (r_q.pulse_bpm < floor_q || r_q.pulse_bpm > ceil_q)))
						stat_q <= ST_BAD_SAMPLE;
					else if (regress) stat_q <= ST_REGRESSION;
					else stat_q <= ST_OK;
				end
			end
			SQ_MUL_W: begin
				if (!half_q) begin
					mlo_q   <= mp;
				end else begin
					w_q <= wide[63:0];
					if (stat_q == ST_OK) begin
						if (act_sum[64]) stat_q <= ST_OVERFLOW;
						else if (pnv_q && a_q != '0) begin
							if (wide[95:64] != '0) stat_q <= ST_OVERFLOW;
						end
					end
				end
			end
			SQ_MUL_D: begin
				dinc_q <= mp;
				if (pnv_q && a_q != '0) begin
					n_wsum_q  <= ws_sum[63:0];
					n_wtime_q <= wt_sum[63:0];
					if (stat_q == ST_OK && (ws_sum[64] || wt_sum[64])) stat_q <= ST_OVERFLOW;
				end else begin
					n_wsum_q  <= wsum_q;
					n_wtime_q <= wtime_q;
				end
			end
			SQ_MUL_E: begin
				einc_q <= mp;
				if (stat_q == ST_OK && !r_q.req_type && !is_cmd_ok) stat_q <= cmd_stat;
			end
			SQ_APPLY:
				if (stat_q == ST_OK && r_q.req_type && n_phase_q == PH_ACTIVE && samp_ovf)
					stat_q <= ST_OVERFLOW;
			SQ_MUL_P:
				if (!half_q) mlo_q <= mp;
				else begin
					pscaled_q <= wide[63:0];
					pace_ok_q <= wide[95:64] == '0;
				end
			SQ_WAIT_A: if (ddone) avg_q <= (wtime_q == '0) ? 64'd0 : dquot;
			SQ_WAIT_P: if (ddone) begin
				out_q.status            <= stat_q;
				out_q.session_state     <= phase_q;
				out_q.total_steps       <= steps_q;
				out_q.total_distance_mm <= dist_q;
				out_q.total_energy      <= en_q;
				out_q.active_time_ms    <= act_q;
				out_q.pulse_stats_valid <= pseen_q;
				out_q.pulse_min_bpm     <= plow_q;
				out_q.pulse_max_bpm     <= phigh_q;
				out_q.pulse_average_bpm <= avg_q[7:0];
				out_q.pace_ms_per_km    <= (dist_q != '0 && pace_ok_q) ? dquot : 64'd0;
			end
			default: ;
		endcase
	end

	assign rsp.valid   = rvalid_q;
	assign rsp.payload = out_q;
endmodule

### hw/rtl/wst_checker.sv
// Port-level checks for the workout session tracker, bound to the top level.
module wst_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [2:0] rsp_status,
	input logic [2:0] rsp_state
);
	import wst_pkg::*;

	a_no_ready_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready) else $error("ready while busy");
	a_no_rsp_early: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !rsp_valid) else $error("response too early");
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status <= ST_BAD_CONFIG && rsp_state <= PH_RECOVERY)
		else $error("bad status code");
endmodule

bind workout_session_tracker wst_checker u_chk (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.payload.status),
	.rsp_state(rsp.payload.session_state)
);
